// ===== rtl/mtsw_pkg.sv =====
`default_nettype none

package mtsw_pkg;

  // default width of the internal time stamps
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned REASON_W = 2;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned REG_W    = 32;
  localparam int unsigned ADDR_W   = 4;

  // input tdata: now_ms, disp_busy, new_phase, wake_flag, zero pad
  localparam int unsigned IN_FIELDS_W = NOW_W + 1 + PHASE_W + 1;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // output tdata: stall_reason, stall_phase, uptime, busy, stale, trip_total
  localparam int unsigned OUT_FIELDS_W = REASON_W + PHASE_W + 4 * NOW_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 3'd0,
    CMD_POLL    = 3'd1,
    CMD_PROG    = 3'd2,
    CMD_WAKE    = 3'd3,
    CMD_CONSUME = 3'd4
  } cmd_t;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE = 2'd0,
    RSN_BUSY = 2'd1,
    RSN_MAIN = 2'd2,
    RSN_WAKE = 2'd3
  } reason_t;

  localparam logic [PHASE_W-1:0] PHASE_BOOT = 3'd0;

  // register indexes (byte address 4*index)
  localparam logic [1:0] REG_MAIN_STALE = 2'd0;
  localparam logic [1:0] REG_SCHED_BUSY = 2'd1;
  localparam logic [1:0] REG_ABS_BUSY   = 2'd2;
  localparam logic [1:0] REG_WAKE_RES   = 2'd3;

  localparam logic [REG_W-1:0] MAIN_STALE_RST = 32'd150000;
  localparam logic [REG_W-1:0] SCHED_BUSY_RST = 32'd90000;
  localparam logic [REG_W-1:0] ABS_BUSY_RST   = 32'd180000;
  localparam logic [REG_W-1:0] WAKE_RES_RST   = 32'd180000;

endpackage

`default_nettype wire

// ===== rtl/multi_timeout_stall_watchdog.sv =====
`default_nettype none

// event-driven stall watchdog with a sticky recovery record
//
// in_*  : command beats; in_tuser carries the command code, in_tdata the time
//         stamp and per-command arguments
// out_* : one result beat per command beat, in order; out_tuser flags a trip
//         or a pending record report, out_tdata carries the record fields
//         (all zero when neither flag is set)
// cfg_* : APB-style register port, four 32-bit limits at byte address 4*i,
//         pready is tied high, reads return the register value
//
// path: an accepted beat waits in the input register until the result
//   register is free, then its result is registered there and driven on out_*
// throughput: 1 beat per cycle while the receiver takes results, set by the
//   single input register feeding the subtract/compare logic and the result register
// a stalled receiver holds the result register; the input register keeps
// taking one more beat, after which in_tready drops until out_tready returns
// reset clears the runtime state, the record and both pipeline valids, and
// loads the default limits
module multi_timeout_stall_watchdog #(
  parameter int unsigned TIME_BITS = mtsw_pkg::TIME_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // tuser: command[2:0]
  input  wire  [mtsw_pkg::CMD_W-1:0]          in_tuser,
  // tdata: now_ms[31:0], disp_busy[32], new_phase[35:33], wake_flag[36], pad
  input  wire  [mtsw_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // tuser: tripped[0], report_pending[1]
  output logic [mtsw_pkg::OUT_USER_W-1:0]     out_tuser,
  // tdata: stall_reason[1:0], stall_phase[4:2], trip_time_ms[36:5], busy_ms[68:37],
  //        stale_ms[100:69], trip_total[132:101], pad
  output logic [mtsw_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [mtsw_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire  [mtsw_pkg::REG_W-1:0]          cfg_pwdata,
  output logic [mtsw_pkg::REG_W-1:0]          cfg_prdata,
  output logic                                cfg_pready
);

  // common width for compares between time differences and 32-bit limits
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned NW = mtsw_pkg::NOW_W;
  localparam int unsigned PW = mtsw_pkg::PHASE_W;

  // ---------------- configuration registers ----------------
  logic [mtsw_pkg::REG_W-1:0] lim_main_r, lim_sched_r, lim_abs_r, lim_wake_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_main_r  <= mtsw_pkg::MAIN_STALE_RST;
      lim_sched_r <= mtsw_pkg::SCHED_BUSY_RST;
      lim_abs_r   <= mtsw_pkg::ABS_BUSY_RST;
      lim_wake_r  <= mtsw_pkg::WAKE_RES_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        mtsw_pkg::REG_MAIN_STALE: lim_main_r  <= cfg_pwdata;
        mtsw_pkg::REG_SCHED_BUSY: lim_sched_r <= cfg_pwdata;
        mtsw_pkg::REG_ABS_BUSY:   lim_abs_r   <= cfg_pwdata;
        mtsw_pkg::REG_WAKE_RES:   lim_wake_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      mtsw_pkg::REG_MAIN_STALE: cfg_prdata = lim_main_r;
      mtsw_pkg::REG_SCHED_BUSY: cfg_prdata = lim_sched_r;
      mtsw_pkg::REG_ABS_BUSY:   cfg_prdata = lim_abs_r;
      mtsw_pkg::REG_WAKE_RES:   cfg_prdata = lim_wake_r;
      default:                  cfg_prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                               s1_valid_r;
  logic [mtsw_pkg::CMD_W-1:0]         s1_cmd_r;
  logic [mtsw_pkg::IN_DATA_W-1:0]     s1_data_r;
  logic                               advance;
  logic                               s1_fire;

  assign advance   = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
  end

  // unpack the registered beat
  logic [NW-1:0]        f_now;
  logic                 f_dbusy;
  logic [PW-1:0]        f_phase;
  logic                 f_wflag;
  logic [TIME_BITS-1:0] now_t;

  assign f_now   = s1_data_r[NW-1:0];
  assign f_dbusy = s1_data_r[NW];
  assign f_phase = s1_data_r[NW+PW:NW+1];
  assign f_wflag = s1_data_r[NW+PW+1];
  assign now_t   = TIME_BITS'(CW'(f_now));

  // ---------------- watchdog state ----------------
  logic                         guard_on_r, guard_on_nxt;
  logic [TIME_BITS-1:0]         busy_since_r, busy_since_nxt;
  logic [TIME_BITS-1:0]         progress_time_r, progress_time_nxt;
  logic [PW-1:0]                cur_phase_r, cur_phase_nxt;
  logic                         wake_active_r, wake_active_nxt;
  logic [TIME_BITS-1:0]         wake_since_r, wake_since_nxt;
  logic                         rec_pending_r, rec_pending_nxt;
  logic [mtsw_pkg::CNT_W-1:0]   rec_count_r, rec_count_nxt;
  logic [mtsw_pkg::REASON_W-1:0] rec_reason_r, rec_reason_nxt;
  logic [PW-1:0]                rec_phase_r, rec_phase_nxt;
  logic [NW-1:0]                rec_uptime_r, rec_uptime_nxt;
  logic [NW-1:0]                rec_busy_r, rec_busy_nxt;
  logic [NW-1:0]                rec_stale_r, rec_stale_nxt;

  // result register contents
  logic [mtsw_pkg::OUT_USER_W-1:0] out_tuser_nxt;
  logic [mtsw_pkg::OUT_DATA_W-1:0] out_tdata_nxt;

  // durations: an unset stamp or time running backward reads as zero
  logic [TIME_BITS-1:0]          busy_for, stale_for, wake_for;
  logic [mtsw_pkg::REG_W-1:0]    dlimit;
  logic                          hit_main, hit_wake, hit_busy, trip;
  mtsw_pkg::reason_t             reason;

  always_comb begin
    busy_for = '0;
    if (f_dbusy && busy_since_r != '0 && now_t >= busy_since_r) begin
      busy_for = now_t - busy_since_r;
    end
    stale_for = '0;
    if (progress_time_r != '0 && now_t >= progress_time_r) begin
      stale_for = now_t - progress_time_r;
    end
    wake_for = '0;
    if (wake_active_r && wake_since_r != '0 && now_t >= wake_since_r) begin
      wake_for = now_t - wake_since_r;
    end
    dlimit   = wake_active_r ? lim_sched_r : lim_abs_r;
    hit_main = CW'(stale_for) >= CW'(lim_main_r);
    hit_wake = CW'(wake_for)  >= CW'(lim_wake_r);
    hit_busy = CW'(busy_for)  >= CW'(dlimit);
    // staleness first, then wake overrun, then display busy
    if (hit_main)      reason = mtsw_pkg::RSN_MAIN;
    else if (hit_wake) reason = mtsw_pkg::RSN_WAKE;
    else if (hit_busy) reason = mtsw_pkg::RSN_BUSY;
    else               reason = mtsw_pkg::RSN_NONE;
  end

  assign trip = (s1_cmd_r == mtsw_pkg::CMD_POLL) && guard_on_r &&
                (reason != mtsw_pkg::RSN_NONE);

  always_comb begin
    guard_on_nxt      = guard_on_r;
    busy_since_nxt    = busy_since_r;
    progress_time_nxt = progress_time_r;
    cur_phase_nxt     = cur_phase_r;
    wake_active_nxt   = wake_active_r;
    wake_since_nxt    = wake_since_r;
    rec_pending_nxt   = rec_pending_r;
    rec_count_nxt     = rec_count_r;
    rec_reason_nxt    = rec_reason_r;
    rec_phase_nxt     = rec_phase_r;
    rec_uptime_nxt    = rec_uptime_r;
    rec_busy_nxt      = rec_busy_r;
    rec_stale_nxt     = rec_stale_r;
    out_tuser_nxt     = '0;
    out_tdata_nxt     = '0;

    case (s1_cmd_r)
      mtsw_pkg::CMD_START: begin
        if (!guard_on_r) begin
          guard_on_nxt = 1'b1;
          if (progress_time_r == '0) progress_time_nxt = now_t;
        end
      end
      mtsw_pkg::CMD_POLL: begin
        if (guard_on_r) begin
          if (!f_dbusy)                  busy_since_nxt = '0;
          else if (busy_since_r == '0)   busy_since_nxt = now_t;
          if (trip) begin
            rec_pending_nxt = 1'b1;
            rec_count_nxt   = rec_count_r + 1'b1;
            rec_reason_nxt  = reason;
            rec_phase_nxt   = cur_phase_r;
            rec_uptime_nxt  = NW'(CW'(now_t));
            rec_busy_nxt    = NW'(CW'(busy_for));
            rec_stale_nxt   = NW'(CW'(stale_for));
            out_tuser_nxt   = 2'b01;
            out_tdata_nxt   = mtsw_pkg::OUT_DATA_W'({rec_count_nxt, rec_stale_nxt,
                                rec_busy_nxt, rec_uptime_nxt, rec_phase_nxt,
                                rec_reason_nxt});
            // stand-in for the restart: runtime state back to its reset values
            guard_on_nxt      = 1'b0;
            busy_since_nxt    = '0;
            progress_time_nxt = '0;
            cur_phase_nxt     = mtsw_pkg::PHASE_BOOT;
            wake_active_nxt   = 1'b0;
            wake_since_nxt    = '0;
          end
        end
      end
      mtsw_pkg::CMD_PROG: begin
        cur_phase_nxt     = f_phase;
        progress_time_nxt = now_t;
      end
      mtsw_pkg::CMD_WAKE: begin
        wake_active_nxt = f_wflag;
        if (f_wflag && !wake_active_r) wake_since_nxt = now_t;
        else if (!f_wflag)             wake_since_nxt = '0;
      end
      mtsw_pkg::CMD_CONSUME: begin
        if (rec_pending_r) begin
          out_tuser_nxt = 2'b10;
          out_tdata_nxt = mtsw_pkg::OUT_DATA_W'({rec_count_r, rec_stale_r, rec_busy_r,
                            rec_uptime_r, rec_phase_r, rec_reason_r});
        end
        rec_pending_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_on_r      <= 1'b0;
      busy_since_r    <= '0;
      progress_time_r <= '0;
      cur_phase_r     <= mtsw_pkg::PHASE_BOOT;
      wake_active_r   <= 1'b0;
      wake_since_r    <= '0;
      rec_pending_r   <= 1'b0;
      rec_count_r     <= '0;
      rec_reason_r    <= '0;
      rec_phase_r     <= '0;
      rec_uptime_r    <= '0;
      rec_busy_r      <= '0;
      rec_stale_r     <= '0;
    end else if (s1_fire) begin
      guard_on_r      <= guard_on_nxt;
      busy_since_r    <= busy_since_nxt;
      progress_time_r <= progress_time_nxt;
      cur_phase_r     <= cur_phase_nxt;
      wake_active_r   <= wake_active_nxt;
      wake_since_r    <= wake_since_nxt;
      rec_pending_r   <= rec_pending_nxt;
      rec_count_r     <= rec_count_nxt;
      rec_reason_r    <= rec_reason_nxt;
      rec_phase_r     <= rec_phase_nxt;
      rec_uptime_r    <= rec_uptime_nxt;
      rec_busy_r      <= rec_busy_nxt;
      rec_stale_r     <= rec_stale_nxt;
    end
  end

  // ---------------- result register ----------------
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [mtsw_pkg::OUT_USER_W-1:0] out_user_r;
  logic [mtsw_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_user_r <= out_tuser_nxt;
      out_data_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // a result never flags both a trip and a record report
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("trip and report flagged together");

  // unflagged results carry all-zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == '0) |-> (out_tdata == '0))
    else $error("unflagged result carries data");

  // a trip drops the guard and bumps the trip count
  a_trip_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && trip) |=> (!guard_on_r && rec_pending_r &&
                           rec_count_r == $past(rec_count_r) + 1'b1))
    else $error("trip did not restart and count");

  // input backpressure only when both pipeline registers are held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
